### rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg - shared types and constants of the life cell generation engine
// Grid geometry, command and register codes, payload structs and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg_pkg;

	// grid geometry
	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 32;
	localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
	localparam int XW          = $clog2(GRID_WIDTH);
	localparam int YW          = $clog2(GRID_HEIGHT);
	localparam int AW          = $clog2(CELLS);
	// memory address: grid bit on top of the cell index
	localparam int MAW         = AW + 1;
	localparam int MEM_DEPTH   = 2 ** MAW;

	// command codes
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_SWAP   = 2'd2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WRAP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNDER_THR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PREV_INFL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_COL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BORN_COL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DIED_COL   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_COL   = 3'd7;

	// neighbor read sequence: slot 0 is the cell itself, 1..8 the neighbors
	localparam int         KW       = 4;
	localparam logic [KW-1:0] K_SELF = 4'd0;
	localparam logic [KW-1:0] K_LAST = 4'd8;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  col;
		logic [4:0]  row;
		logic        alive_in;
		logic [15:0] color_in;
		logic [9:0]  rand_draw;
	} req_item_t;

	typedef struct packed {
		logic        new_alive;
		logic [15:0] new_color;
		logic [3:0]  neighbor_count;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic          latch;
		logic          clear_wr;
		logic          cell_wr;
		logic          swap;
		logic          rd_en;
		logic [KW-1:0] rd_k;
		logic          decide;
		logic          blend;
		logic          next_wr;
		logic          load_out;
	} lcg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       on_grid;
		logic       clear_last;
	} lcg_status_t;

endpackage

`default_nettype wire

### rtl/lcg_ctrl.sv
// ----------------------------------------------------------------------------
// lcg_ctrl - sequencer of the life cell generation engine
// Runs the clearing pass after reset, decodes each command and steps the
// datapath through the nine reads, decision, blend and write of an update.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	input  wire lcg_pkg::lcg_status_t status,
	output lcg_pkg::lcg_cmd_t        cmd
);
	import lcg_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DRAIN,
		ST_DECIDE,
		ST_BLEND,
		ST_NEXT_WR,
		ST_RESULT
	} state_t;

	state_t        state_q;
	logic [KW-1:0] k_q;
	logic          out_valid_q;
	logic          is_update;

	assign is_update = (status.cmd == CMD_UPDATE) && status.on_grid;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	// command decode per state
	always_comb begin
		cmd          = '0;
		cmd.rd_k     = k_q;
		unique case (state_q)
			ST_CLEAR:   cmd.clear_wr = 1'b1;
			ST_IDLE:    cmd.latch    = req_valid;
			ST_EXEC: begin
				cmd.cell_wr = (status.cmd == CMD_WRITE) && status.on_grid;
				cmd.swap    = (status.cmd == CMD_SWAP);
			end
			ST_READ:    cmd.rd_en    = 1'b1;
			ST_DRAIN:   ;
			ST_DECIDE:  cmd.decide   = 1'b1;
			ST_BLEND:   cmd.blend    = 1'b1;
			ST_NEXT_WR: cmd.next_wr  = 1'b1;
			ST_RESULT:  cmd.load_out = !out_valid_q || !rsp_stall;
		endcase
	end

	// state, read slot counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			k_q         <= K_SELF;
			out_valid_q <= 1'b0;
		end else begin
			// transfer on the result side frees the output register
			if (out_valid_q && !rsp_stall && !cmd.load_out)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					k_q <= K_SELF;
					if (is_update)
						state_q <= ST_READ;
					else
						state_q <= ST_RESULT;
				end
				ST_READ: begin
					k_q <= k_q + KW'(1);
					if (k_q == K_LAST)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN:   state_q <= ST_DECIDE;
				ST_DECIDE:  state_q <= ST_BLEND;
				ST_BLEND:   state_q <= ST_NEXT_WR;
				ST_NEXT_WR: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (!out_valid_q || !rsp_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/lcg_datapath.sv
// ----------------------------------------------------------------------------
// lcg_datapath - grids, registers and arithmetic of the life cell engine
// Holds both alive and colour grids, the configuration registers, the
// neighbor address generator, the counter, the rule and the colour blend.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lcg_pkg::req_item_t            req,
	input  wire logic                          cfg_wr_en,
	input  wire logic [lcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lcg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire lcg_pkg::lcg_cmd_t             cmd,
	output lcg_pkg::lcg_status_t               status,
	output lcg_pkg::rsp_item_t                 rsp
);
	import lcg_pkg::*;

	localparam logic [1:0] OFS_MINUS = 2'd0;
	localparam logic [1:0] OFS_SAME  = 2'd1;
	localparam logic [1:0] OFS_PLUS  = 2'd2;

	// configuration registers
	logic        edge_wrap_q;
	logic [9:0]  under_thr_q;
	logic [9:0]  over_thr_q;
	logic [7:0]  prev_infl_q;
	logic [23:0] alive_col_q;
	logic [23:0] born_col_q;
	logic [23:0] died_col_q;
	logic [23:0] dead_col_q;

	// item and update state
	logic [1:0]     cmd_q;
	logic           on_grid_q;
	logic [XW-1:0]  col_q;
	logic [YW-1:0]  row_q;
	logic           alive_in_q;
	logic [15:0]    color_in_q;
	logic [9:0]     draw_q;
	logic           sel_q;
	logic [MAW-1:0] clr_q;
	logic [3:0]     count_q;
	logic           self_q;
	logic [15:0]    prev_q;
	logic           now_q;
	logic [23:0]    base_q;
	logic [15:0]    new_col_q;
	rsp_item_t      rsp_q;

	// memories and read pipeline
	logic           alive_mem [MEM_DEPTH];
	logic [15:0]    color_mem [MEM_DEPTH];
	logic           alive_rd_s1;
	logic [15:0]    color_rd_s1;
	logic           rd_en_s1;
	logic           nb_ok_s1;
	logic [KW-1:0]  k_s1;

	// address generation
	logic [1:0]     dx, dy;
	logic [XW-1:0]  nx;
	logic [YW-1:0]  ny;
	logic           x_ok, y_ok;
	logic           col_lo, col_hi, row_lo, row_hi;
	logic [AW-1:0]  self_idx, nb_idx;
	logic [MAW-1:0] rd_addr, wr_addr;
	logic           wr_en, wr_col_en, wr_alive;
	logic [15:0]    wr_color;

	// rule and blend
	logic           now_c;
	logic [23:0]    base_c;
	logic [7:0]     br, bg, bb;
	logic [15:0]    blend_c;

	function automatic logic [AW-1:0] cell_idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
		return AW'(y) * AW'(GRID_WIDTH) + AW'(x);
	endfunction

	// (base * (255 - p) + prev * p) >> 8; the sum never exceeds 16 bits
	function automatic logic [7:0] blend_ch(input logic [7:0] b, input logic [7:0] pv,
			input logic [7:0] p);
		logic [15:0] sum;
		sum = {8'd0, b} * {8'd0, 8'd255 - p} + {8'd0, pv} * {8'd0, p};
		return sum[15:8];
	endfunction

	assign status.cmd        = cmd_q;
	assign status.on_grid    = on_grid_q;
	assign status.clear_last = &clr_q;
	assign rsp               = rsp_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_wrap_q <= 1'b1;
			under_thr_q <= 10'd990;
			over_thr_q  <= 10'd950;
			prev_infl_q <= 8'd0;
			alive_col_q <= 24'd0;
			born_col_q  <= 24'd0;
			died_col_q  <= 24'd0;
			dead_col_q  <= 24'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_EDGE_WRAP: edge_wrap_q <= cfg_wdata[0];
				CFG_UNDER_THR: under_thr_q <= cfg_wdata[9:0];
				CFG_OVER_THR:  over_thr_q  <= cfg_wdata[9:0];
				CFG_PREV_INFL: prev_infl_q <= cfg_wdata[7:0];
				CFG_ALIVE_COL: alive_col_q <= cfg_wdata;
				CFG_BORN_COL:  born_col_q  <= cfg_wdata;
				CFG_DIED_COL:  died_col_q  <= cfg_wdata;
				CFG_DEAD_COL:  dead_col_q  <= cfg_wdata;
			endcase
		end
	end

	// clearing pass counter and grid select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (cmd.clear_wr)
				clr_q <= clr_q + MAW'(1);
			if (cmd.swap)
				sel_q <= ~sel_q;
		end
	end

	// item capture on an accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= CMD_WRITE;
			on_grid_q <= 1'b0;
		end else if (cmd.latch) begin
			cmd_q     <= req.cmd;
			on_grid_q <= (int'(req.col) < GRID_WIDTH) && (int'(req.row) < GRID_HEIGHT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			col_q      <= XW'(req.col);
			row_q      <= YW'(req.row);
			alive_in_q <= req.alive_in;
			color_in_q <= req.color_in;
			draw_q     <= req.rand_draw;
		end
	end

	// neighbor offset for each read slot
	always_comb begin
		unique case (cmd.rd_k)
			4'd1:    begin dx = OFS_MINUS; dy = OFS_MINUS; end
			4'd2:    begin dx = OFS_MINUS; dy = OFS_SAME;  end
			4'd3:    begin dx = OFS_MINUS; dy = OFS_PLUS;  end
			4'd4:    begin dx = OFS_SAME;  dy = OFS_MINUS; end
			4'd5:    begin dx = OFS_SAME;  dy = OFS_PLUS;  end
			4'd6:    begin dx = OFS_PLUS;  dy = OFS_MINUS; end
			4'd7:    begin dx = OFS_PLUS;  dy = OFS_SAME;  end
			4'd8:    begin dx = OFS_PLUS;  dy = OFS_PLUS;  end
			default: begin dx = OFS_SAME;  dy = OFS_SAME;  end
		endcase
	end

	// neighbor coordinate with wrap, flagged when it leaves the grid
	assign col_lo = (col_q == '0);
	assign col_hi = (col_q == XW'(GRID_WIDTH - 1));
	assign row_lo = (row_q == '0);
	assign row_hi = (row_q == YW'(GRID_HEIGHT - 1));

	always_comb begin
		unique case (dx)
			OFS_MINUS: begin
				nx   = col_lo ? XW'(GRID_WIDTH - 1) : col_q - XW'(1);
				x_ok = edge_wrap_q || !col_lo;
			end
			OFS_PLUS: begin
				nx   = col_hi ? '0 : col_q + XW'(1);
				x_ok = edge_wrap_q || !col_hi;
			end
			default: begin
				nx   = col_q;
				x_ok = 1'b1;
			end
		endcase
		unique case (dy)
			OFS_MINUS: begin
				ny   = row_lo ? YW'(GRID_HEIGHT - 1) : row_q - YW'(1);
				y_ok = edge_wrap_q || !row_lo;
			end
			OFS_PLUS: begin
				ny   = row_hi ? '0 : row_q + YW'(1);
				y_ok = edge_wrap_q || !row_hi;
			end
			default: begin
				ny   = row_q;
				y_ok = 1'b1;
			end
		endcase
	end

	assign self_idx = cell_idx(col_q, row_q);
	assign nb_idx   = cell_idx(nx, ny);
	assign rd_addr  = {sel_q, nb_idx};

	// write port: clearing pass, cell write to current grid, update to next
	always_comb begin
		wr_en     = 1'b0;
		wr_col_en = 1'b0;
		wr_addr   = clr_q;
		wr_alive  = 1'b0;
		wr_color  = color_in_q;
		priority if (cmd.clear_wr) begin
			wr_en = 1'b1;
		end else if (cmd.cell_wr) begin
			wr_en     = 1'b1;
			wr_col_en = 1'b1;
			wr_addr   = {sel_q, self_idx};
			wr_alive  = alive_in_q;
		end else if (cmd.next_wr) begin
			wr_en     = 1'b1;
			wr_col_en = 1'b1;
			wr_addr   = {~sel_q, self_idx};
			wr_alive  = now_q;
			wr_color  = new_col_q;
		end
	end

	// grid memories, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			alive_mem[wr_addr] <= wr_alive;
		if (wr_col_en)
			color_mem[wr_addr] <= wr_color;
		alive_rd_s1 <= alive_mem[rd_addr];
		color_rd_s1 <= color_mem[rd_addr];
	end

	// read tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_en_s1 <= 1'b0;
		else
			rd_en_s1 <= cmd.rd_en;
	end

	always_ff @(posedge clk) begin
		k_s1     <= cmd.rd_k;
		nb_ok_s1 <= x_ok && y_ok;
	end

	// self capture and neighbor count
	always_ff @(posedge clk) begin
		if (cmd.latch)
			count_q <= 4'd0;
		else if (rd_en_s1) begin
			if (k_s1 == K_SELF) begin
				self_q <= alive_rd_s1;
				prev_q <= color_rd_s1;
			end else begin
				count_q <= count_q + {3'd0, alive_rd_s1 && nb_ok_s1};
			end
		end
	end

	// birth on 3 or 6, survival on 2 or 3, chance survival otherwise
	always_comb begin
		if (self_q) begin
			if (count_q < 4'd2)
				now_c = draw_q > under_thr_q;
			else if (count_q <= 4'd3)
				now_c = 1'b1;
			else
				now_c = draw_q > over_thr_q;
		end else begin
			now_c = (count_q == 4'd3) || (count_q == 4'd6);
		end
		unique case ({now_c, self_q})
			2'b11: base_c = alive_col_q;
			2'b10: base_c = born_col_q;
			2'b01: base_c = died_col_q;
			2'b00: base_c = dead_col_q;
		endcase
	end

	// blend base with previous colour, pack to RGB565
	always_comb begin
		if (prev_infl_q != 8'd0) begin
			br = blend_ch(base_q[23:16], {prev_q[15:11], 3'd0}, prev_infl_q);
			bg = blend_ch(base_q[15:8],  {prev_q[10:5],  2'd0}, prev_infl_q);
			bb = blend_ch(base_q[7:0],   {prev_q[4:0],   3'd0}, prev_infl_q);
		end else begin
			br = base_q[23:16];
			bg = base_q[15:8];
			bb = base_q[7:0];
		end
		blend_c = {br[7:3], bg[7:2], bb[7:3]};
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			now_q  <= now_c;
			base_q <= base_c;
		end
		if (cmd.blend)
			new_col_q <= blend_c;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if ((cmd_q == CMD_UPDATE) && on_grid_q) begin
				rsp_q.new_alive      <= now_q;
				rsp_q.new_color      <= new_col_q;
				rsp_q.neighbor_count <= count_q;
			end else begin
				rsp_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/life_cell_generation_engine.sv
// ----------------------------------------------------------------------------
// life_cell_generation_engine - double-buffered life grid with colour
// Top level: controller and datapath, plus a few checks on their cooperation.
// ----------------------------------------------------------------------------
// Each request returns exactly one result. Write stores a cell into the
// current grid, swap exchanges current and next grid, and update counts the
// eight neighbors in the current grid, applies the B36/S23 rule with random
// survival outside it, and stores the new alive bit and blended colour in the
// next grid; write, swap, unused codes and off-grid cells answer all zeros.
// Write and swap pass only through the execute and result states; update
// steps through nine reads (cell plus eight neighbors) through the single
// read port of the alive-grid memory, followed by drain, decide, blend and write.
// After reset a clearing pass over all 4096 entries marks every cell dead; requests
// are stalled meanwhile, configuration writes are taken at any time.
// A finished result sits in an output register, so the next request is taken
// while the result still waits for its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module life_cell_generation_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire lcg_pkg::req_item_t            req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output lcg_pkg::rsp_item_t                 rsp,
	input  wire logic                          cfg_wr_en,
	input  wire logic [lcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lcg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lcg_pkg::*;

	lcg_cmd_t    cmd;
	lcg_status_t status;

	lcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lcg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.rsp       (rsp)
	);

	// no request is taken during the clearing pass
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> req_stall)
		else $error("request accepted during clearing pass");

	// the memory write port has one source at a time
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cmd.cell_wr, cmd.next_wr}))
		else $error("conflicting grid writes");

	// a result is loaded only into a free or draining output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid || !rsp_stall))
		else $error("result overwrote a pending result");

	// one request at a time: a transfer is followed by a stall
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second request taken while one is in work");

endmodule

`default_nettype wire

### bench/life_cell_generation_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cell_generation_engine_tb - self-checking bench for the life grid engine
// Drives write, update, swap and unused commands over the valid/stall request
// channel. A scoreboard keeps its own copy of both grids and the registers and
// checks every result field in order. Random idle gaps on both sides and one
// long response hold-off fill the block up. Most random traffic is
// write-window / update / swap generations, near edges and corners as well.
// ----------------------------------------------------------------------------

module life_cell_generation_engine_tb;

	import lcg_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 600000;
	localparam int         LONG_HOLD   = 400;
	localparam int         HOLD_AFTER  = 300;
	localparam int         PHASES      = 6;
	localparam int         PHASE_ITEMS = 115;

	// ------------------------------------------------------------------------
	// scoreboard: shadow grids, registers and the queue of next-generation
	// results still to come
	// ------------------------------------------------------------------------
	class cell_scoreboard;
		bit          alive_map [2][CELLS];
		logic [15:0] hue_map   [2][CELLS];
		bit          sel;
		bit          wrap;
		logic [9:0]  under_thr;
		logic [9:0]  over_thr;
		logic [7:0]  infl;
		logic [23:0] alive_rgb, born_rgb, died_rgb, dead_rgb;
		rsp_item_t   next_gen_q[$];
		int          errors;

		function new();
			foreach (alive_map[g, i]) begin
				alive_map[g][i] = 1'b0;
				hue_map[g][i]   = '0;
			end
			sel       = 1'b0;
			wrap      = 1'b1;
			under_thr = 10'd990;
			over_thr  = 10'd950;
			infl      = '0;
			alive_rgb = '0;
			born_rgb  = '0;
			died_rgb  = '0;
			dead_rgb  = '0;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_EDGE_WRAP: wrap      = d[0];
				CFG_UNDER_THR: under_thr = d[9:0];
				CFG_OVER_THR:  over_thr  = d[9:0];
				CFG_PREV_INFL: infl      = d[7:0];
				CFG_ALIVE_COL: alive_rgb = d;
				CFG_BORN_COL:  born_rgb  = d;
				CFG_DIED_COL:  died_rgb  = d;
				CFG_DEAD_COL:  dead_rgb  = d;
				default: ;
			endcase
		endfunction

		function int count_live(int c, int r);
			int n, nc, nr;
			n = 0;
			for (int dc = -1; dc <= 1; dc++) begin
				for (int dr = -1; dr <= 1; dr++) begin
					if (dc == 0 && dr == 0) continue;
					nc = c + dc;
					nr = r + dr;
					if (wrap) begin
						nc = (nc + GRID_WIDTH) % GRID_WIDTH;
						nr = (nr + GRID_HEIGHT) % GRID_HEIGHT;
					end else if (nc < 0 || nc >= GRID_WIDTH || nr < 0 || nr >= GRID_HEIGHT) begin
						continue;
					end
					if (alive_map[sel][nr * GRID_WIDTH + nc]) n++;
				end
			end
			return n;
		endfunction

		// base colour by (now, was_alive), optionally blended with the old RGB565
		function logic [15:0] blend_hue(bit now, bit was_alive, logic [15:0] prev);
			logic [23:0] base;
			logic [31:0] ch [3];
			logic [31:0] pv [3];
			base  = now ? (was_alive ? alive_rgb : born_rgb)
			            : (was_alive ? died_rgb : dead_rgb);
			ch[0] = 32'(base[23:16]);
			ch[1] = 32'(base[15:8]);
			ch[2] = 32'(base[7:0]);
			pv[0] = 32'({prev[15:11], 3'b000});
			pv[1] = 32'({prev[10:5], 2'b00});
			pv[2] = 32'({prev[4:0], 3'b000});
			if (infl != 0) begin
				for (int k = 0; k < 3; k++)
					ch[k] = ((ch[k] * (32'd255 - 32'(infl)) + pv[k] * 32'(infl)) >> 8)
						& 32'hFF;
			end
			return {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
		endfunction

		// evolve the grids for one accepted request and queue its result
		function void note_request(req_item_t it);
			rsp_item_t   e;
			int          idx, n;
			bit          was_alive, now;
			logic [15:0] hue;
			e   = '0;
			idx = int'(it.row) * GRID_WIDTH + int'(it.col);
			case (it.cmd)
				CMD_WRITE: begin
					alive_map[sel][idx] = it.alive_in;
					hue_map[sel][idx]   = it.color_in;
				end
				CMD_UPDATE: begin
					n         = count_live(int'(it.col), int'(it.row));
					was_alive = alive_map[sel][idx];
					if (was_alive) begin
						if (n < 2)       now = it.rand_draw > under_thr;
						else if (n <= 3) now = 1'b1;
						else             now = it.rand_draw > over_thr;
					end else begin
						now = (n == 3 || n == 6);
					end
					hue = blend_hue(now, was_alive, hue_map[sel][idx]);
					alive_map[!sel][idx] = now;
					hue_map[!sel][idx]   = hue;
					e.new_alive      = now;
					e.new_color      = hue;
					e.neighbor_count = n[3:0];
				end
				CMD_SWAP: sel = !sel;
				default: ;
			endcase
			next_gen_q.push_back(e);
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t e;
			if (next_gen_q.size() == 0) begin
				$error("result with nothing pending: %h", got);
				errors++;
				return;
			end
			e = next_gen_q.pop_front();
			if (got.new_alive !== e.new_alive) begin
				$error("new_alive expected %0d got %0d", e.new_alive, got.new_alive);
				errors++;
			end
			if (got.new_color !== e.new_color) begin
				$error("new_color expected %h got %h", e.new_color, got.new_color);
				errors++;
			end
			if (got.neighbor_count !== e.neighbor_count) begin
				$error("neighbor_count expected %0d got %0d", e.neighbor_count,
					got.neighbor_count);
				errors++;
			end
		endfunction

		function int pending();
			return next_gen_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals and DUT
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_item_t             req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_item_t             rsp;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	cell_scoreboard sb = new();

	// generator-side view: which colour entries hold a written value
	bit hue_set [2][CELLS];
	bit gen_sel     = 1'b0;
	int items_sent  = 0;
	bit hold_done   = 1'b0;
	int cycles      = 0;

	life_cell_generation_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result transfers
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			sb.check_result(rsp);
	end

	// ------------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------------
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic req_item_t mk(logic [1:0] cmd, int c, int r, bit a,
			logic [15:0] hue, logic [9:0] draw);
		req_item_t it;
		it.cmd       = cmd;
		it.col       = c[5:0];
		it.row       = r[4:0];
		it.alive_in  = a;
		it.color_in  = hue;
		it.rand_draw = draw;
		return it;
	endfunction

	function automatic req_item_t mk_rand(logic [1:0] cmd, int c, int r, bit a);
		return mk(cmd, c, r, a, 16'($urandom_range(0, 16'hFFFF)),
			10'($urandom_range(0, 1023)));
	endfunction

	function automatic int cell_of(int c, int r);
		return (r % GRID_HEIGHT) * GRID_WIDTH + (c % GRID_WIDTH);
	endfunction

	// ------------------------------------------------------------------------
	// request driver; valid stays high across back-to-back transfers
	// ------------------------------------------------------------------------
	task automatic send_req(input req_item_t it);
		int unsigned gap;
		int          idx;
		idx = int'(it.row) * GRID_WIDTH + int'(it.col);
		case (it.cmd)
			CMD_WRITE:  hue_set[gen_sel][idx] = 1'b1;
			CMD_UPDATE: hue_set[!gen_sel][idx] = 1'b1;
			CMD_SWAP:   gen_sel = !gen_sel;
			default: ;
		endcase
		gap = idle_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		sb.note_request(it);
		if (it.cmd != CMD_UNUSED) items_sent++;
	endtask

	// wait until every pending result has been taken
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, d);
	endtask

	task automatic program_regs(input bit wrap, input logic [CFG_DATA_W-1:0] under,
			input logic [CFG_DATA_W-1:0] over, input logic [CFG_DATA_W-1:0] infl,
			input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] b,
			input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] d);
		write_reg(CFG_EDGE_WRAP, CFG_DATA_W'(wrap));
		write_reg(CFG_UNDER_THR, under);
		write_reg(CFG_OVER_THR, over);
		write_reg(CFG_PREV_INFL, infl);
		write_reg(CFG_ALIVE_COL, a);
		write_reg(CFG_BORN_COL, b);
		write_reg(CFG_DIED_COL, c);
		write_reg(CFG_DEAD_COL, d);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_thr();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 1000;
			2:       return 1023;
			default: return CFG_DATA_W'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_rgb();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 24'hFFFFFF;
			default: return CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	// register setting per random phase; the first two pin the extremes, the third nears them
	task automatic program_phase(input int ph);
		logic [CFG_DATA_W-1:0] p;
		case (ph)
			0: program_regs(1'b1, 0, 0, 255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
			1: program_regs(1'b0, 1023, 1023, 0, 0, 0, 0, 0);
			2: program_regs(1'b1, 1000, 1000, 1, pick_rgb(), pick_rgb(), pick_rgb(),
				pick_rgb());
			default: begin
				case ($urandom_range(0, 2))
					0:       p = 0;
					1:       p = 255;
					default: p = CFG_DATA_W'($urandom_range(0, 255));
				endcase
				program_regs(1'($urandom_range(0, 1)), pick_thr(), pick_thr(), p,
					pick_rgb(), pick_rgb(), pick_rgb(), pick_rgb());
			end
		endcase
	endtask

	// one small pattern: fill a window, then run a few generations on it
	task automatic run_window();
		int x0, y0, w, h, dens, gens, c, r;
		if ($urandom_range(0, 99) < 35) begin
			x0 = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(60, 63);
			y0 = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(28, 31);
		end else begin
			x0 = $urandom_range(0, GRID_WIDTH - 1);
			y0 = $urandom_range(0, GRID_HEIGHT - 1);
		end
		w    = $urandom_range(3, 5);
		h    = $urandom_range(3, 4);
		dens = $urandom_range(10, 90);
		gens = $urandom_range(1, 3);
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				c = (x0 + x) % GRID_WIDTH;
				r = (y0 + y) % GRID_HEIGHT;
				send_req(mk_rand(CMD_WRITE, c, r, $urandom_range(0, 99) < dens));
			end
		end
		for (int g = 0; g < gens; g++) begin
			for (int y = 0; y < h; y++) begin
				for (int x = 0; x < w; x++) begin
					c = (x0 + x) % GRID_WIDTH;
					r = (y0 + y) % GRID_HEIGHT;
					if (hue_set[gen_sel][cell_of(c, r)])
						send_req(mk_rand(CMD_UPDATE, c, r, 1'($urandom_range(0, 1))));
				end
			end
			send_req(mk_rand(CMD_SWAP, $urandom_range(0, 63), $urandom_range(0, 31),
				1'($urandom_range(0, 1))));
		end
	endtask

	// scattered single commands, broken sequences and the unused code
	task automatic noise_item();
		int roll, c, r;
		roll = $urandom_range(0, 99);
		c    = $urandom_range(0, GRID_WIDTH - 1);
		r    = $urandom_range(0, GRID_HEIGHT - 1);
		if (roll < 10)
			send_req(mk_rand(CMD_UNUSED, c, r, 1'($urandom_range(0, 1))));
		else if (roll < 25)
			send_req(mk_rand(CMD_SWAP, c, r, 1'($urandom_range(0, 1))));
		else if (roll < 60 && hue_set[gen_sel][cell_of(c, r)])
			send_req(mk_rand(CMD_UPDATE, c, r, 1'($urandom_range(0, 1))));
		else
			send_req(mk_rand(CMD_WRITE, c, r, 1'($urandom_range(0, 1))));
	endtask

	// ------------------------------------------------------------------------
	// response back-pressure, with one long hold-off once traffic is going
	// ------------------------------------------------------------------------
	initial begin
		int unsigned n;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && items_sent >= HOLD_AFTER) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			n = idle_len();
			if (n != 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 8)) @(posedge clk);
			else                            repeat ($urandom_range(40, 200)) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners with wrap, chance survival both ways, unused code
		program_regs(1'b1, 500, 500, 0, 24'hFFFFFF, 24'h00FF00, 24'hFF0000, 24'h000000);
		send_req(mk(CMD_WRITE, 0, 0, 1'b1, 16'hFFFF, 10'd0));
		send_req(mk(CMD_WRITE, 63, 0, 1'b1, 16'h0000, 10'd1023));
		send_req(mk(CMD_WRITE, 0, 31, 1'b1, 16'h1234, 10'd0));
		send_req(mk(CMD_WRITE, 63, 31, 1'b1, 16'hFFFF, 10'd1023));
		send_req(mk(CMD_WRITE, 1, 1, 1'b0, 16'hAAAA, 10'd512));
		send_req(mk(CMD_UPDATE, 0, 0, 1'b0, 16'h0000, 10'd0));
		send_req(mk(CMD_UPDATE, 63, 31, 1'b1, 16'hFFFF, 10'd1023));
		send_req(mk(CMD_UPDATE, 1, 1, 1'b0, 16'h5555, 10'd512));
		send_req(mk(CMD_UNUSED, 63, 31, 1'b1, 16'hFFFF, 10'd1023));
		send_req(mk(CMD_SWAP, 0, 0, 1'b0, 16'h0000, 10'd0));
		send_req(mk(CMD_UPDATE, 0, 0, 1'b0, 16'h0000, 10'd1023));
		send_req(mk(CMD_UPDATE, 63, 31, 1'b0, 16'h0000, 10'd0));
		send_req(mk(CMD_SWAP, 63, 31, 1'b1, 16'hFFFF, 10'd1023));

		// seven live neighbors around a dead centre: no birth
		send_req(mk(CMD_WRITE, 10, 5, 1'b1, 16'hF800, 10'd0));
		send_req(mk(CMD_WRITE, 11, 5, 1'b1, 16'h07E0, 10'd0));
		send_req(mk(CMD_WRITE, 12, 5, 1'b1, 16'h001F, 10'd0));
		send_req(mk(CMD_WRITE, 10, 6, 1'b1, 16'h8410, 10'd0));
		send_req(mk(CMD_WRITE, 12, 6, 1'b1, 16'h4208, 10'd0));
		send_req(mk(CMD_WRITE, 10, 7, 1'b1, 16'h2104, 10'd0));
		send_req(mk(CMD_WRITE, 11, 7, 1'b1, 16'h1082, 10'd0));
		send_req(mk(CMD_WRITE, 11, 6, 1'b0, 16'hC618, 10'd0));
		send_req(mk(CMD_UPDATE, 11, 6, 1'b0, 16'h0000, 10'd999));

		// no wrap at the corners, full previous-colour weight
		settle();
		program_regs(1'b0, 1023, 0, 255, 24'h123456, 24'hFEDCBA, 24'h0F0F0F, 24'hF0F0F0);
		send_req(mk(CMD_UPDATE, 0, 0, 1'b1, 16'hFFFF, 10'd999));
		send_req(mk(CMD_UPDATE, 63, 31, 1'b0, 16'h0000, 10'd0));

		// random phases, one register setting each
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			program_phase(ph);
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(0, 99) < 70) run_window();
				else                            noise_item();
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
